// File: src/tmos_pkg.sv
// ----------------------------------------------------------------------------
// tmos_pkg
// Shared types and constants for the two-machine open shop ranker: beat
// payloads for the job and result channels and the job class codes.
// ----------------------------------------------------------------------------
package tmos_pkg;

	localparam int TIME_W      = 16;
	localparam int RANK_W      = 7;
	localparam int JOB_INDEX_W = 6;

	// job classes by processing times
	typedef enum logic [1:0] {
		CLS_1 = 2'd0, // 0 < t1 <= t2
		CLS_2 = 2'd1, // t1 > t2 > 0
		CLS_3 = 2'd2, // t1 == 0
		CLS_4 = 2'd3  // t1 > t2 == 0
	} cls_t;

	// one job beat
	typedef struct packed {
		logic [TIME_W-1:0] time_m1;
		logic [TIME_W-1:0] time_m2;
		logic              op_m1_present;
		logic              op_m2_present;
		logic              last_job;
	} job_t;

	// one result beat
	typedef struct packed {
		logic [JOB_INDEX_W-1:0] job_index;
		logic [RANK_W-1:0]      rank_m1;
		logic [RANK_W-1:0]      rank_m2;
		logic                   inconsistent;
		logic                   last_result;
	} result_t;

endpackage

// File: src/tmos_stream_if.sv
// ----------------------------------------------------------------------------
// tmos_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface tmos_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: src/two_machine_open_shop_ranker_core.sv
// ----------------------------------------------------------------------------
// two_machine_open_shop_ranker_core
// Operation: one job beat per cycle while loading; after the last job, a class
//   scan and four rank passes over the stored jobs, with the S_PICK and S_SPEC
//   selection steps, then one result beat at a time, held under backpressure.
// Throughput is set by the single read port of each job store and the shared
//   rank write and rank counters; one instance is processed at a time.
// Reset: arst_n clears the sequencer, job count and output valid; the job
//   stores hold no reset value and are only read where written.
// ----------------------------------------------------------------------------
module two_machine_open_shop_ranker_core #(
	parameter int MAX_JOBS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	tmos_stream_if.sink   jobs,
	tmos_stream_if.source ranks
);
	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int TW = 2 * tmos_pkg::TIME_W;
	localparam int RW = 2 * tmos_pkg::RANK_W;

	typedef enum logic [9:0] {
		S_LOAD     = 10'b00_0000_0001,
		S_SCAN     = 10'b00_0000_0010,
		S_PICK     = 10'b00_0000_0100,
		S_R1       = 10'b00_0000_1000,
		S_R2       = 10'b00_0001_0000,
		S_SPEC     = 10'b00_0010_0000,
		S_R4       = 10'b00_0100_0000,
		S_R3       = 10'b00_1000_0000,
		S_OUT_RD   = 10'b01_0000_0000,
		S_OUT_WAIT = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	logic   out_ld_q;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_j_q;
	logic [CW-1:0] out_j_q;
	logic          valid_s1;
	logic [AW-1:0] j_s1;

	logic                        have_k_q, have_l_q, have_v_q;
	logic [AW-1:0]               k_idx_q, l_idx_q, special_q;
	logic [tmos_pkg::TIME_W-1:0] k_t1_q, l_t2_q;
	logic [tmos_pkg::RANK_W-1:0] next_q, z_q;

	tmos_pkg::result_t out_q;
	logic              out_valid_q;

	// ram ports
	logic          time_we, flag_we, cls_we, rank_we;
	logic [AW-1:0] load_addr, rank_waddr;
	logic [TW-1:0] time_wdata, time_rdata;
	logic          flag_wdata, flag_rdata;
	logic [1:0]    cls_wdata, cls_rdata;
	logic [RW-1:0] rank_wdata, rank_rdata;

	logic          accept, take, in_pass, issuing, pass_done;
	logic [tmos_pkg::TIME_W-1:0] t1_s1, t2_s1;
	tmos_pkg::cls_t cls_s1, target_cls;
	logic          rank_hit;

	// handshake
	assign jobs.ready    = (state_q == S_LOAD);
	assign accept        = jobs.valid && jobs.ready;
	assign ranks.valid   = out_valid_q;
	assign ranks.payload = out_q;
	assign take          = ranks.valid && ranks.ready;

	// job store writes while loading
	assign load_addr  = cnt_q[AW-1:0];
	assign time_we    = accept && (cnt_q < CW'(MAX_JOBS));
	assign flag_we    = time_we;
	assign time_wdata = {jobs.payload.time_m2, jobs.payload.time_m1};
	assign flag_wdata = (jobs.payload.op_m1_present && (jobs.payload.time_m1 == '0))
		|| (jobs.payload.op_m2_present && (jobs.payload.time_m2 == '0));

	// pass sequencing: one read issued per cycle, data handled in the cycle after
	assign in_pass   = (state_q == S_SCAN) || (state_q == S_R1) || (state_q == S_R2)
		|| (state_q == S_R4) || (state_q == S_R3);
	assign issuing   = in_pass && (rd_j_q < cnt_q);
	assign pass_done = in_pass && !issuing && !valid_s1;

	// class decision on scanned times
	assign t1_s1 = time_rdata[tmos_pkg::TIME_W-1:0];
	assign t2_s1 = time_rdata[TW-1:tmos_pkg::TIME_W];
	always_comb begin
		if (t1_s1 <= t2_s1) begin
			cls_s1 = (t1_s1 == '0) ? tmos_pkg::CLS_3 : tmos_pkg::CLS_1;
		end else begin
			cls_s1 = (t2_s1 == '0) ? tmos_pkg::CLS_4 : tmos_pkg::CLS_2;
		end
	end
	assign cls_we    = valid_s1 && (state_q == S_SCAN);
	assign cls_wdata = cls_s1;

	// class served by the current rank pass
	always_comb begin
		unique case (state_q)
			S_R1:    target_cls = tmos_pkg::CLS_1;
			S_R2:    target_cls = tmos_pkg::CLS_2;
			S_R4:    target_cls = tmos_pkg::CLS_4;
			S_R3:    target_cls = tmos_pkg::CLS_3;
			default: target_cls = tmos_pkg::CLS_1;
		endcase
	end

	assign rank_hit = valid_s1 && (state_q != S_SCAN)
		&& (cls_rdata == target_cls) && !(have_v_q && (j_s1 == special_q));

	// shared rank write: special job or the entry of the current pass
	always_comb begin
		rank_we    = 1'b0;
		rank_waddr = j_s1;
		rank_wdata = '0;
		unique case (state_q)
			S_SPEC: begin
				rank_we    = have_v_q;
				rank_waddr = special_q;
				rank_wdata = {tmos_pkg::RANK_W'(1), next_q};
			end
			S_R1, S_R2: begin
				rank_we    = rank_hit;
				rank_wdata = {next_q + tmos_pkg::RANK_W'(1), next_q};
			end
			S_R4: begin
				rank_we    = rank_hit;
				rank_wdata = {tmos_pkg::RANK_W'(0), next_q};
			end
			S_R3: begin
				rank_we    = rank_hit;
				rank_wdata = {z_q, tmos_pkg::RANK_W'(0)};
			end
			default: begin
				rank_we = 1'b0;
			end
		endcase
	end

	tmos_ram #(.WIDTH(TW), .DEPTH(MAX_JOBS)) u_time_ram (
		.clk   (clk),
		.we    (time_we),
		.waddr (load_addr),
		.wdata (time_wdata),
		.raddr (rd_j_q[AW-1:0]),
		.rdata (time_rdata)
	);

	tmos_ram #(.WIDTH(1), .DEPTH(MAX_JOBS)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (load_addr),
		.wdata (flag_wdata),
		.raddr (out_j_q[AW-1:0]),
		.rdata (flag_rdata)
	);

	tmos_ram #(.WIDTH(2), .DEPTH(MAX_JOBS)) u_cls_ram (
		.clk   (clk),
		.we    (cls_we),
		.waddr (j_s1),
		.wdata (cls_wdata),
		.raddr (rd_j_q[AW-1:0]),
		.rdata (cls_rdata)
	);

	tmos_ram #(.WIDTH(RW), .DEPTH(MAX_JOBS)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (rank_wdata),
		.raddr (out_j_q[AW-1:0]),
		.rdata (rank_rdata)
	);

	// pass read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rd_j_q   <= '0;
		end else begin
			valid_s1 <= issuing;
			if (issuing) begin
				rd_j_q <= rd_j_q + CW'(1);
			end else if (pass_done) begin
				rd_j_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= rd_j_q[AW-1:0];
	end

	// longest class 1 job on machine one, longest class 2 job on machine two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_k_q <= 1'b0;
			have_l_q <= 1'b0;
		end else if (accept) begin
			have_k_q <= 1'b0;
			have_l_q <= 1'b0;
		end else if (valid_s1 && (state_q == S_SCAN)) begin
			if ((cls_s1 == tmos_pkg::CLS_1) && (!have_k_q || (t1_s1 > k_t1_q))) begin
				have_k_q <= 1'b1;
			end
			if ((cls_s1 == tmos_pkg::CLS_2) && (!have_l_q || (t2_s1 > l_t2_q))) begin
				have_l_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && (state_q == S_SCAN)) begin
			if ((cls_s1 == tmos_pkg::CLS_1) && (!have_k_q || (t1_s1 > k_t1_q))) begin
				k_idx_q <= j_s1;
				k_t1_q  <= t1_s1;
			end
			if ((cls_s1 == tmos_pkg::CLS_2) && (!have_l_q || (t2_s1 > l_t2_q))) begin
				l_idx_q <= j_s1;
				l_t2_q  <= t2_s1;
			end
		end
	end

	// special job choice, ties to machine one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_v_q  <= 1'b0;
			special_q <= '0;
		end else if (state_q == S_PICK) begin
			have_v_q <= have_k_q || have_l_q;
			priority if (have_k_q && have_l_q) begin
				special_q <= (k_t1_q >= l_t2_q) ? k_idx_q : l_idx_q;
			end else if (have_k_q) begin
				special_q <= k_idx_q;
			end else if (have_l_q) begin
				special_q <= l_idx_q;
			end else begin
				special_q <= '0;
			end
		end
	end

	// rank counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= tmos_pkg::RANK_W'(1);
			z_q    <= tmos_pkg::RANK_W'(1);
		end else begin
			if (state_q == S_PICK) begin
				next_q <= tmos_pkg::RANK_W'(1);
			end else if (state_q == S_SPEC) begin
				next_q <= next_q + tmos_pkg::RANK_W'(have_v_q);
				z_q    <= next_q + tmos_pkg::RANK_W'(have_v_q);
			end else if (rank_hit && (state_q == S_R3)) begin
				z_q <= z_q + tmos_pkg::RANK_W'(1);
			end else if (rank_hit) begin
				next_q <= next_q + tmos_pkg::RANK_W'(1);
			end
		end
	end

	// sequencer, job count and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			out_j_q     <= '0;
			out_ld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_ld_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (time_we) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (jobs.payload.last_job) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (pass_done) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					state_q <= S_R1;
				end
				S_R1: begin
					if (pass_done) begin
						state_q <= S_R2;
					end
				end
				S_R2: begin
					if (pass_done) begin
						state_q <= S_SPEC;
					end
				end
				S_SPEC: begin
					state_q <= S_R4;
				end
				S_R4: begin
					if (pass_done) begin
						state_q <= S_R3;
					end
				end
				S_R3: begin
					if (pass_done) begin
						state_q <= S_OUT_RD;
					end
				end
				S_OUT_RD: begin
					out_ld_q <= 1'b1;
					state_q  <= S_OUT_WAIT;
				end
				S_OUT_WAIT: begin
					if (out_ld_q) begin
						out_valid_q <= 1'b1;
					end else if (take) begin
						out_valid_q <= 1'b0;
						if (out_q.last_result) begin
							cnt_q   <= '0;
							out_j_q <= '0;
							state_q <= S_LOAD;
						end else begin
							out_j_q <= out_j_q + CW'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// result payload from the rank and flag stores
	always_ff @(posedge clk) begin
		if (out_ld_q) begin
			out_q.job_index    <= tmos_pkg::JOB_INDEX_W'(out_j_q);
			out_q.rank_m1      <= rank_rdata[tmos_pkg::RANK_W-1:0];
			out_q.rank_m2      <= rank_rdata[RW-1:tmos_pkg::RANK_W];
			out_q.inconsistent <= flag_rdata;
			out_q.last_result  <= (out_j_q == (cnt_q - CW'(1)));
		end
	end

`ifndef NO_ASSERTIONS
	// no job beat taken while a result is pending
	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		jobs.ready |-> !out_valid_q)
		else $error("job beat accepted while a result is pending");

	// job count never passes the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_JOBS))
		else $error("job count beyond store depth");

	// rank writes only land on stored jobs
	a_rank_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rank_we |-> (CW'(rank_waddr) < cnt_q))
		else $error("rank written outside the stored jobs");

	// final result beat returns the block to loading with an empty store
	a_last_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(take && out_q.last_result) |=> (state_q == S_LOAD) && (cnt_q == '0))
		else $error("block did not return to loading after the final result");

	// result valid only while a result is being offered
	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == S_OUT_WAIT))
		else $error("result valid outside the result phase");
`endif
endmodule

// File: src/tmos_ram.sv
// ----------------------------------------------------------------------------
// tmos_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tmos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: dv/tmos_rank_checker.sv
// ----------------------------------------------------------------------------
// tmos_rank_checker
// Watches the job and rank channels of the open shop ranker, keeps its own
// copy of the jobs of the current instance, works out the latin-rectangle
// ranks when the last job beat is taken and compares every rank beat, field
// by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module tmos_rank_checker #(
	parameter int MAX_JOBS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  logic              job_ready,
	input  tmos_pkg::job_t    job_beat,
	input  logic              rank_valid,
	input  logic              rank_ready,
	input  tmos_pkg::result_t rank_beat,
	output int                fails,
	output int                pending,
	output int                checked
);
	timeunit 1ns;
	timeprecision 1ps;

	tmos_pkg::job_t    held_jobs[$];
	tmos_pkg::result_t due_ranks[$];

	// class of a job from its two times
	function automatic tmos_pkg::cls_t job_class(tmos_pkg::job_t j);
		if (j.time_m1 <= j.time_m2) begin
			return (j.time_m1 == '0) ? tmos_pkg::CLS_3 : tmos_pkg::CLS_1;
		end
		return (j.time_m2 == '0) ? tmos_pkg::CLS_4 : tmos_pkg::CLS_2;
	endfunction

	// deal out ranks for the held jobs and queue one result per job
	function automatic void rank_instance();
		int                          n;
		int                          k;
		int                          l;
		int                          spec;
		int                          y;
		int                          z;
		bit                          has_k;
		bit                          has_l;
		bit                          has_spec;
		tmos_pkg::cls_t              cls[MAX_JOBS];
		logic [tmos_pkg::RANK_W-1:0] r1[MAX_JOBS];
		logic [tmos_pkg::RANK_W-1:0] r2[MAX_JOBS];
		tmos_pkg::result_t           res;
		n = held_jobs.size();
		k = 0;
		l = 0;
		spec = 0;
		has_k = 1'b0;
		has_l = 1'b0;
		has_spec = 1'b0;
		// longest class 1 job on machine one, longest class 2 job on machine two
		for (int j = 0; j < n; j++) begin
			cls[j] = job_class(held_jobs[j]);
			if (cls[j] == tmos_pkg::CLS_1
					&& (!has_k || held_jobs[j].time_m1 > held_jobs[k].time_m1)) begin
				k = j;
				has_k = 1'b1;
			end
			if (cls[j] == tmos_pkg::CLS_2
					&& (!has_l || held_jobs[j].time_m2 > held_jobs[l].time_m2)) begin
				l = j;
				has_l = 1'b1;
			end
		end
		// machine one wins a tie
		if (has_k && has_l) begin
			spec = (held_jobs[k].time_m1 >= held_jobs[l].time_m2) ? k : l;
			has_spec = 1'b1;
		end else if (has_k) begin
			spec = k;
			has_spec = 1'b1;
		end else if (has_l) begin
			spec = l;
			has_spec = 1'b1;
		end
		y = 1;
		for (int j = 0; j < n; j++) begin
			if (cls[j] == tmos_pkg::CLS_1 && !(has_spec && j == spec)) begin
				r1[j] = tmos_pkg::RANK_W'(y);
				r2[j] = tmos_pkg::RANK_W'(y + 1);
				y++;
			end
		end
		for (int j = 0; j < n; j++) begin
			if (cls[j] == tmos_pkg::CLS_2 && !(has_spec && j == spec)) begin
				r1[j] = tmos_pkg::RANK_W'(y);
				r2[j] = tmos_pkg::RANK_W'(y + 1);
				y++;
			end
		end
		if (has_spec) begin
			r1[spec] = tmos_pkg::RANK_W'(y);
			r2[spec] = tmos_pkg::RANK_W'(1);
			y++;
		end
		z = y;
		for (int j = 0; j < n; j++) begin
			if (cls[j] == tmos_pkg::CLS_4) begin
				r1[j] = tmos_pkg::RANK_W'(y);
				r2[j] = '0;
				y++;
			end
		end
		// class 3 restarts from the count just after the special job
		for (int j = 0; j < n; j++) begin
			if (cls[j] == tmos_pkg::CLS_3) begin
				r1[j] = '0;
				r2[j] = tmos_pkg::RANK_W'(z);
				z++;
			end
		end
		for (int j = 0; j < n; j++) begin
			res.job_index    = tmos_pkg::JOB_INDEX_W'(j);
			res.rank_m1      = r1[j];
			res.rank_m2      = r2[j];
			res.inconsistent = (held_jobs[j].op_m1_present && held_jobs[j].time_m1 == '0) ||
				(held_jobs[j].op_m2_present && held_jobs[j].time_m2 == '0);
			res.last_result  = (j == n - 1);
			due_ranks.push_back(res);
		end
	endfunction

	// compare a rank beat with the oldest expected one
	function automatic void check_rank(tmos_pkg::result_t got);
		tmos_pkg::result_t want;
		if (due_ranks.size() == 0) begin
			$error("unexpected rank beat: job_index %0d", got.job_index);
			fails++;
			return;
		end
		want = due_ranks.pop_front();
		checked++;
		if (got.job_index !== want.job_index) begin
			$error("job_index: expected %0d, got %0d", want.job_index, got.job_index);
			fails++;
		end
		if (got.rank_m1 !== want.rank_m1) begin
			$error("rank_m1: expected %0d, got %0d", want.rank_m1, got.rank_m1);
			fails++;
		end
		if (got.rank_m2 !== want.rank_m2) begin
			$error("rank_m2: expected %0d, got %0d", want.rank_m2, got.rank_m2);
			fails++;
		end
		if (got.inconsistent !== want.inconsistent) begin
			$error("inconsistent: expected %0b, got %0b", want.inconsistent, got.inconsistent);
			fails++;
		end
		if (got.last_result !== want.last_result) begin
			$error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
			fails++;
		end
	endfunction

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_jobs.delete();
			due_ranks.delete();
			fails = 0;
			checked = 0;
		end else begin
			if (rank_valid && rank_ready) begin
				check_rank(rank_beat);
			end
			if (job_valid && job_ready) begin
				// jobs beyond a full store are dropped
				if (held_jobs.size() < MAX_JOBS) begin
					held_jobs.push_back(job_beat);
				end
				if (job_beat.last_job) begin
					rank_instance();
					held_jobs.delete();
				end
			end
		end
		pending = due_ranks.size();
	end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives job instances into the open shop ranker: a directed set covering
// field extremes, tie breaks and empty classes, then random instances of
// mixed size including a full job store with dropped jobs, under three mixes
// of sender gaps and receiver stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_JOBS = 64;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	int   jobs_sent;
	int   instances;
	int   fails;
	int   pending;
	int   checked;

	tmos_stream_if #(.payload_t(tmos_pkg::job_t))    jobs_ch ();
	tmos_stream_if #(.payload_t(tmos_pkg::result_t)) ranks_ch ();

	two_machine_open_shop_ranker_core #(
		.MAX_JOBS(MAX_JOBS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.jobs  (jobs_ch),
		.ranks (ranks_ch)
	);

	tmos_rank_checker #(
		.MAX_JOBS(MAX_JOBS)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (jobs_ch.valid),
		.job_ready (jobs_ch.ready),
		.job_beat  (jobs_ch.payload),
		.rank_valid(ranks_ch.valid),
		.rank_ready(ranks_ch.ready),
		.rank_beat (ranks_ch.payload),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk) begin
		ranks_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// one job beat, with random gaps before it
	task automatic send_job(input logic [tmos_pkg::TIME_W-1:0] t1,
			input logic [tmos_pkg::TIME_W-1:0] t2,
			input logic p1, input logic p2, input logic last);
		tmos_pkg::job_t j;
		j.time_m1       = t1;
		j.time_m2       = t2;
		j.op_m1_present = p1;
		j.op_m2_present = p2;
		j.last_job      = last;
		while ($urandom_range(99) < idle_pct) begin
			jobs_ch.valid <= 1'b0;
			@(posedge clk);
		end
		jobs_ch.valid   <= 1'b1;
		jobs_ch.payload <= j;
		@(posedge clk);
		while (!jobs_ch.ready) @(posedge clk);
		jobs_sent++;
		if (last) begin
			instances++;
		end
	endtask

	// hold off the sender until every rank beat has come back
	task automatic drain();
		jobs_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// zero, tiny, a copy of the other time or anything
	function automatic logic [tmos_pkg::TIME_W-1:0] pick_time(
			logic [tmos_pkg::TIME_W-1:0] other);
		case ($urandom_range(4))
			0: return '0;
			1: return tmos_pkg::TIME_W'($urandom_range(1, 8));
			2: return other;
			default: return tmos_pkg::TIME_W'($urandom_range(65535));
		endcase
	endfunction

	task automatic random_instance(input int n);
		logic [tmos_pkg::TIME_W-1:0] t1;
		logic [tmos_pkg::TIME_W-1:0] t2;
		for (int i = 0; i < n; i++) begin
			t1 = pick_time(tmos_pkg::TIME_W'($urandom_range(65535)));
			t2 = pick_time(t1);
			send_job(t1, t2, 1'($urandom_range(1)), 1'($urandom_range(1)), i == n - 1);
		end
	endtask

	// set the gap and stall mix for the next stretch
	task automatic set_mix(input int idle, input int stall);
		drain();
		idle_pct  = idle;
		stall_pct = stall;
	endtask

	initial begin
		int n;
		arst_n          = 1'b0;
		jobs_ch.valid   = 1'b0;
		jobs_ch.payload = '0;
		ranks_ch.ready  = 1'b0;
		idle_pct        = 17;
		stall_pct       = 61;
		jobs_sent       = 0;
		instances       = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single jobs: zero times with both flags, then both times full scale
		send_job(16'd0, 16'd0, 1'b1, 1'b1, 1'b1);
		send_job(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		// every class at the extremes, flags marking zero times
		send_job(16'hFFFF, 16'd0, 1'b1, 1'b1, 1'b0);
		send_job(16'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		send_job(16'hFFFF, 16'd1, 1'b1, 1'b1, 1'b0);
		send_job(16'd1, 16'hFFFF, 1'b0, 1'b1, 1'b0);
		send_job(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
		send_job(16'd0, 16'd0, 1'b0, 1'b0, 1'b1);
		// tie between machines and ties inside each class
		send_job(16'd500, 16'd600, 1'b1, 1'b1, 1'b0);
		send_job(16'd900, 16'd500, 1'b1, 1'b1, 1'b0);
		send_job(16'd500, 16'd700, 1'b0, 1'b1, 1'b0);
		send_job(16'd800, 16'd500, 1'b1, 1'b0, 1'b1);
		// only class 2 jobs
		send_job(16'd5, 16'd3, 1'b1, 1'b1, 1'b0);
		send_job(16'd9, 16'd7, 1'b0, 1'b0, 1'b0);
		send_job(16'd4, 16'd1, 1'b1, 1'b1, 1'b1);
		// classes 1 and 2 empty, no special job
		send_job(16'd0, 16'd4, 1'b0, 1'b1, 1'b0);
		send_job(16'd7, 16'd0, 1'b1, 1'b0, 1'b0);
		send_job(16'd0, 16'd0, 1'b0, 1'b1, 1'b0);
		send_job(16'd3, 16'd0, 1'b0, 1'b0, 1'b1);
		// class 2 candidate longer than class 1 candidate
		send_job(16'd10, 16'd20, 1'b1, 1'b1, 1'b0);
		send_job(16'd30, 16'd25, 1'b1, 1'b1, 1'b1);

		// random instances, mostly small
		while (jobs_sent < 360) begin
			if (jobs_sent >= 140 && idle_pct == 17) begin
				set_mix(61, 17);
				random_instance(MAX_JOBS);
			end else if (jobs_sent >= 250 && idle_pct == 61) begin
				set_mix(0, 0);
				// store overflows, last job itself is dropped
				random_instance(MAX_JOBS + 6);
			end else begin
				n = ($urandom_range(11) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
				random_instance(n);
			end
		end

		drain();
		repeat (700) @(posedge clk);
		if (pending != 0) begin
			$error("%0d rank beats never arrived", pending);
		end
		$display("covered %0d jobs in %0d instances, %0d rank beats checked", jobs_sent,
			instances, checked);
		$display("incl. tie breaks, empty classes and a full job store, three gap/stall mixes");
		if (fails == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
